// ----- src/nbrp_pkg.sv -----
// Package for the nonzero-balanced row partition core.
// Holds sizes, field codes, sequencer states and the weight-unit control struct.
// No dependencies.
`default_nettype none

package nbrp_pkg;

    // Storage sizes
    localparam int OFFSET_DEPTH = 4096;
    localparam int MAX_DEVICES  = 16;

    // Field widths
    localparam int VALUE_W   = 32;
    localparam int DEV_ID_W  = 16;
    localparam int OUT_ROW_W = 12;

    // Derived widths
    localparam int ROW_W   = $clog2(OFFSET_DEPTH);
    localparam int CNT_W   = $clog2(OFFSET_DEPTH + 1);
    localparam int DCNT_W  = $clog2(MAX_DEVICES + 1);
    localparam int DIDX_W  = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    // prefix weight: signed offset difference plus row number
    localparam int PW_W    = VALUE_W + 2;
    // prefix weight scaled by the device count, and the running target
    localparam int PROD_W  = PW_W + DCNT_W + 1;
    localparam int DIFF_W  = PROD_W + 1;

    // Item kinds
    localparam logic KIND_OFFSET = 1'b0;
    localparam logic KIND_DEVICE = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_TOT,
        S_TOT2,
        S_DEV,
        S_SCHK,
        S_RD,
        S_PW,
        S_MUL,
        S_CMP,
        S_EMIT
    } t_state;

    // What a weight evaluation feeds back into
    typedef enum logic [1:0] {
        RET_SRCH,
        RET_ABOVE,
        RET_BELOW
    } t_ret;

    // Weight unit control
    typedef struct packed {
        logic pw_en;
        logic use_last;
        logic mul_en;
    } t_wu_ctrl;

endpackage : nbrp_pkg

`default_nettype wire

// ----- src/nbrp_offset_ram.sv -----
// Row-start offset store: one write port, one registered read port.
// Depends on nbrp_pkg.
`default_nettype none

module nbrp_offset_ram
    import nbrp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [ROW_W-1:0]   i_waddr,
    input  wire logic [VALUE_W-1:0] i_wdata,
    input  wire logic [ROW_W-1:0]   i_raddr,
    output logic      [VALUE_W-1:0] o_rdata
);

    logic [VALUE_W-1:0] mem [OFFSET_DEPTH];

    // Write on load
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule : nbrp_offset_ram

`default_nettype wire

// ----- src/nbrp_weight_unit.sv -----
// Shared arithmetic unit: prefix weight of a row, then scaled by the device count.
// Two register stages (subtract/add, multiply). Depends on nbrp_pkg.
`default_nettype none

module nbrp_weight_unit
    import nbrp_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_wu_ctrl                 i_ctrl,
    input  wire logic [VALUE_W-1:0]       i_rdata,
    input  wire logic [VALUE_W-1:0]       i_off_last,
    input  wire logic [VALUE_W-1:0]       i_off0,
    input  wire logic [ROW_W-1:0]         i_addr,
    input  wire logic [DCNT_W-1:0]        i_k,
    output logic signed [PW_W-1:0]        o_pw,
    output logic signed [PROD_W-1:0]      o_prod
);

    logic [VALUE_W-1:0]       src;
    logic signed [PROD_W-1:0] k_ext;
    logic signed [PROD_W-1:0] pw_ext;

    assign src    = i_ctrl.use_last ? i_off_last : i_rdata;
    assign k_ext  = PROD_W'($signed({1'b0, i_k}));
    assign pw_ext = PROD_W'(o_pw);

    // Prefix weight: offset[r] - offset[0] + r, exact in PW_W signed bits
    always_ff @(posedge i_clk) begin
        if (i_ctrl.pw_en) begin
            o_pw <= $signed(PW_W'(src) - PW_W'(i_off0) + PW_W'(i_addr));
        end
    end

    // Scale by the device count
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            o_prod <= pw_ext * k_ext;
        end
    end

endmodule : nbrp_weight_unit

`default_nettype wire

// ----- src/nonzero_balanced_row_partition_core.sv -----
// Nonzero-balanced row partition core: loads CSR row offsets and device ids,
// then emits one row range per device. Load: one transaction per cycle.
// After the final device the input stalls: total weight, then per range but the last a
// binary search (p <= ceil(log2(m + 1)) probes), a check of the row below when the cut
// lies above the range start, and the emit; output stalls hold each emit.
// Synchronous active-low reset clears the sequencer, counts and dropped flag.
`default_nettype none

module nonzero_balanced_row_partition_core
    import nbrp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_kind,
    input  wire logic [VALUE_W-1:0]    i_value,
    input  wire logic                  i_last,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [DEV_ID_W-1:0]        o_device_id,
    output logic [OUT_ROW_W-1:0]       o_first_row,
    output logic [OUT_ROW_W-1:0]       o_end_row,
    output logic                       o_last_range,
    output logic                       o_overflow
);

    t_state                   r_state, n_state;
    t_ret                     r_ret, n_ret;
    logic [CNT_W-1:0]         r_off_count, n_off_count;
    logic [DCNT_W-1:0]        r_dev_count, n_dev_count;
    logic                     r_dropped, n_dropped;
    logic [VALUE_W-1:0]       r_off0, n_off0;
    logic [VALUE_W-1:0]       r_off_last, n_off_last;
    logic [ROW_W-1:0]         r_m, n_m;
    logic [ROW_W-1:0]         r_addr, n_addr;
    logic [ROW_W-1:0]         r_low, n_low;
    logic [ROW_W-1:0]         r_high, n_high;
    logic [ROW_W-1:0]         r_range_start, n_range_start;
    logic [ROW_W-1:0]         r_end, n_end;
    logic [DCNT_W-1:0]        r_i, n_i;
    logic signed [PW_W-1:0]   r_total, n_total;
    logic signed [PROD_W-1:0] r_target, n_target;
    logic signed [DIFF_W-1:0] r_above, n_above;
    logic [DEV_ID_W-1:0]      r_dev_store [MAX_DEVICES];

    logic                     mem_we;
    logic                     dev_we;
    logic [VALUE_W-1:0]       rdata;
    t_wu_ctrl                 wu_ctrl;
    logic signed [PW_W-1:0]   wu_pw;
    logic signed [PROD_W-1:0] wu_prod;
    logic [ROW_W-1:0]         mid;
    logic [ROW_W-1:0]         m_val;
    logic [DCNT_W-1:0]        i_next;
    logic                     last_dev;
    logic signed [DIFF_W-1:0] below;

    nbrp_offset_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_off_count[ROW_W-1:0]),
        .i_wdata (i_value),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    nbrp_weight_unit u_wu (
        .i_clk      (i_clk),
        .i_ctrl     (wu_ctrl),
        .i_rdata    (rdata),
        .i_off_last (r_off_last),
        .i_off0     (r_off0),
        .i_addr     (r_addr),
        .i_k        (r_dev_count),
        .o_pw       (wu_pw),
        .o_prod     (wu_prod)
    );

    // Search helpers
    assign mid      = r_low + ((r_high - r_low) >> 1);
    assign m_val    = (r_off_count == '0) ? '0 : ROW_W'(r_off_count - 1'b1);
    assign i_next   = DCNT_W'(r_i + 1'b1);
    assign last_dev = (i_next == r_dev_count);
    assign below    = DIFF_W'(r_target) - DIFF_W'(wu_prod);

    // Next state and datapath control
    always_comb begin
        n_state       = r_state;
        n_ret         = r_ret;
        n_off_count   = r_off_count;
        n_dev_count   = r_dev_count;
        n_dropped     = r_dropped;
        n_off0        = r_off0;
        n_off_last    = r_off_last;
        n_m           = r_m;
        n_addr        = r_addr;
        n_low         = r_low;
        n_high        = r_high;
        n_range_start = r_range_start;
        n_end         = r_end;
        n_i           = r_i;
        n_total       = r_total;
        n_target      = r_target;
        n_above       = r_above;
        mem_we        = 1'b0;
        dev_we        = 1'b0;
        wu_ctrl       = '0;

        unique case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    if (i_kind == KIND_OFFSET) begin
                        if (r_off_count < CNT_W'(OFFSET_DEPTH)) begin
                            mem_we = 1'b1;
                            if (r_off_count == '0) begin
                                n_off0 = i_value;
                            end
                            n_off_last  = i_value;
                            n_off_count = r_off_count + 1'b1;
                        end else begin
                            n_dropped = 1'b1;
                        end
                    end else begin
                        if (r_dev_count < DCNT_W'(MAX_DEVICES)) begin
                            dev_we      = 1'b1;
                            n_dev_count = r_dev_count + 1'b1;
                        end else begin
                            n_dropped = 1'b1;
                        end
                        if (i_last) begin
                            n_state = S_INIT;
                        end
                    end
                end
            end
            S_INIT: begin
                n_m           = m_val;
                n_addr        = m_val;
                n_i           = '0;
                n_range_start = '0;
                n_state       = S_TOT;
            end
            S_TOT: begin
                // total weight from the last stored offset
                wu_ctrl.pw_en    = 1'b1;
                wu_ctrl.use_last = 1'b1;
                n_state          = S_TOT2;
            end
            S_TOT2: begin
                n_total  = (r_m != '0) ? wu_pw : '0;
                n_target = (r_m != '0) ? PROD_W'(wu_pw) : '0;
                n_state  = S_DEV;
            end
            S_DEV: begin
                if (i_next < r_dev_count) begin
                    n_low   = r_range_start;
                    n_high  = r_m;
                    n_state = S_SCHK;
                end else begin
                    n_end   = r_m;
                    n_state = S_EMIT;
                end
            end
            S_SCHK: begin
                if (r_low < r_high) begin
                    n_addr  = mid;
                    n_ret   = RET_SRCH;
                    n_state = S_RD;
                end else begin
                    n_end = r_low;
                    if (r_low > r_range_start) begin
                        // check whether the row below lies nearer
                        n_addr  = r_low;
                        n_ret   = RET_ABOVE;
                        n_state = S_RD;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_RD: begin
                n_state = S_PW;
            end
            S_PW: begin
                wu_ctrl.pw_en = 1'b1;
                n_state       = S_MUL;
            end
            S_MUL: begin
                wu_ctrl.mul_en = 1'b1;
                n_state        = S_CMP;
            end
            S_CMP: begin
                unique case (r_ret)
                    RET_SRCH: begin
                        if (wu_prod >= r_target) begin
                            n_high = r_addr;
                        end else begin
                            n_low = r_addr + 1'b1;
                        end
                        n_state = S_SCHK;
                    end
                    RET_ABOVE: begin
                        n_above = DIFF_W'(wu_prod) - DIFF_W'(r_target);
                        n_addr  = r_end - 1'b1;
                        n_ret   = RET_BELOW;
                        n_state = S_RD;
                    end
                    RET_BELOW: begin
                        // ties go to the lower row
                        if (below <= r_above) begin
                            n_end = r_end - 1'b1;
                        end
                        n_state = S_EMIT;
                    end
                    default: begin
                        n_state = S_LOAD;
                    end
                endcase
            end
            S_EMIT: begin
                if (!i_stall) begin
                    n_range_start = r_end;
                    n_i           = i_next;
                    n_target      = r_target + PROD_W'(r_total);
                    if (last_dev) begin
                        n_off_count = '0;
                        n_dev_count = '0;
                        n_dropped   = 1'b0;
                        n_state     = S_LOAD;
                    end else begin
                        n_state = S_DEV;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_off_count <= '0;
            r_dev_count <= '0;
            r_dropped   <= 1'b0;
            r_i         <= '0;
        end else begin
            r_state     <= n_state;
            r_off_count <= n_off_count;
            r_dev_count <= n_dev_count;
            r_dropped   <= n_dropped;
            r_i         <= n_i;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_ret         <= n_ret;
        r_off0        <= n_off0;
        r_off_last    <= n_off_last;
        r_m           <= n_m;
        r_addr        <= n_addr;
        r_low         <= n_low;
        r_high        <= n_high;
        r_range_start <= n_range_start;
        r_end         <= n_end;
        r_total       <= n_total;
        r_target      <= n_target;
        r_above       <= n_above;
    end

    // Device id store
    always_ff @(posedge i_clk) begin
        if (dev_we) begin
            r_dev_store[r_dev_count[DIDX_W-1:0]] <= i_value[DEV_ID_W-1:0];
        end
    end

    // Ports
    assign o_stall      = (r_state != S_LOAD);
    assign o_valid      = (r_state == S_EMIT);
    assign o_device_id  = r_dev_store[r_i[DIDX_W-1:0]];
    assign o_first_row  = OUT_ROW_W'(r_range_start);
    assign o_end_row    = OUT_ROW_W'(r_end);
    assign o_last_range = last_dev;
    assign o_overflow   = r_dropped;

endmodule : nonzero_balanced_row_partition_core

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for nonzero_balanced_row_partition_core.
// Depends on nbrp_pkg and the core; predicts each row range and checks every output transaction.

module testbench;
    import nbrp_pkg::*;

    localparam int RANDOM_ITEMS   = 60;
    localparam int RANDOM_RANGES  = 10;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 300;
    localparam int MAX_PRINTS     = 40;

    // Receiver stall patterns
    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_mode;

    typedef struct packed {
        logic [DEV_ID_W-1:0]  device_id;
        logic [OUT_ROW_W-1:0] first_row;
        logic [OUT_ROW_W-1:0] end_row;
        logic                 last_range;
        logic                 overflow;
    } t_row_range;

    logic                 i_clk;
    logic                 i_rst_n  = 1'b0;
    logic                 i_valid  = 1'b0;
    logic                 i_kind   = KIND_OFFSET;
    logic [VALUE_W-1:0]   i_value  = '0;
    logic                 i_last   = 1'b0;
    logic                 i_stall  = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [DEV_ID_W-1:0]  o_device_id;
    logic [OUT_ROW_W-1:0] o_first_row;
    logic [OUT_ROW_W-1:0] o_end_row;
    logic                 o_last_range;
    logic                 o_overflow;

    // Shadow copy of the block's stores
    logic [VALUE_W-1:0]  offsets_mem [OFFSET_DEPTH];
    logic [DEV_ID_W-1:0] devices_mem [MAX_DEVICES];
    int unsigned         n_offsets = 0;
    int unsigned         n_devices = 0;
    logic                dropped   = 1'b0;

    t_row_range range_q [$];

    int n_sent        = 0;
    int n_predicted   = 0;
    int n_checked     = 0;
    int n_partitions  = 0;
    int mismatches    = 0;
    int burst_left    = 0;
    int hold_requests = 0;

    nonzero_balanced_row_partition_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_value      (i_value),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_device_id  (o_device_id),
        .o_first_row  (o_first_row),
        .o_end_row    (o_end_row),
        .o_last_range (o_last_range),
        .o_overflow   (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Weight of the first r rows: nonzeros plus rows, as a signed difference
    function automatic longint row_weight(int unsigned r);
        return longint'({32'd0, offsets_mem[r]}) - longint'({32'd0, offsets_mem[0]})
               + longint'(r);
    endfunction

    // Split the stored rows over the stored devices and queue one range per device
    function automatic void split_matrix();
        int unsigned m, k, start, lo, hi, mid, stop, i;
        longint      total, target, above, below, kk;
        t_row_range  rr;
        k     = n_devices;
        m     = (n_offsets == 0) ? 0 : n_offsets - 1;
        total = (m > 0) ? row_weight(m) : 0;
        kk    = longint'(k);
        start = 0;
        for (i = 0; i < k; i++) begin
            stop = m;
            if (i + 1 < k) begin
                target = 2 * longint'(i + 1) * total;
                lo = start;
                hi = m;
                // Find the first row whose scaled weight reaches the target
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (2 * kk * row_weight(mid) >= target) hi = mid;
                    else lo = mid + 1;
                end
                stop = lo;
                // Step back one row when it is at least as near; ties go low
                if (stop > start) begin
                    above = 2 * kk * row_weight(stop) - target;
                    below = target - 2 * kk * row_weight(stop - 1);
                    if (below <= above) stop = stop - 1;
                end
            end
            rr.device_id  = devices_mem[i];
            rr.first_row  = OUT_ROW_W'(start);
            rr.end_row    = OUT_ROW_W'(stop);
            rr.last_range = (i + 1 == k);
            rr.overflow   = dropped;
            range_q.insert(range_q.size(), rr);
            n_predicted++;
            start = stop;
        end
        n_offsets = 0;
        n_devices = 0;
        dropped   = 1'b0;
        n_partitions++;
    endfunction

    // Apply one accepted input transaction to the shadow state
    function automatic void absorb_entry(logic kind, logic [VALUE_W-1:0] value, logic last);
        if (kind == KIND_OFFSET) begin
            if (n_offsets < OFFSET_DEPTH) begin
                offsets_mem[n_offsets] = value;
                n_offsets++;
            end else begin
                dropped = 1'b1;
            end
        end else begin
            if (n_devices < MAX_DEVICES) begin
                devices_mem[n_devices] = value[DEV_ID_W-1:0];
                n_devices++;
            end else begin
                dropped = 1'b1;
            end
            if (last) split_matrix();
        end
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // Offer one transaction, hold it until accepted, then maybe pause the sender
    task automatic send_entry(logic kind, logic [VALUE_W-1:0] value, logic last);
        int gap;
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_value <= value;
        i_last  <= last;
        do @(posedge i_clk); while (o_stall);
        absorb_entry(kind, value, last);
        n_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Send rows+1 monotone row-start offsets with random row lengths
    task automatic send_csr_offsets(int rows, logic [VALUE_W-1:0] base, int max_len);
        logic [VALUE_W-1:0] ptr;
        ptr = base;
        for (int r = 0; r <= rows; r++) begin
            send_entry(KIND_OFFSET, ptr, 1'($urandom_range(0, 1)));
            ptr = ptr + $urandom_range(0, max_len);
        end
    endtask

    // Send a device list with random ids; the final one starts the partition
    task automatic send_device_list(int count);
        logic [VALUE_W-1:0] v;
        for (int d = 0; d < count; d++) begin
            v = $urandom();
            send_entry(KIND_DEVICE, v, d == count - 1);
        end
    endtask

    // Drop valid and wait for every expected range
    task automatic drain_ranges();
        i_valid <= 1'b0;
        while (range_q.size() != 0) @(posedge i_clk);
    endtask

    // Empty matrices (no offsets, one offset), ties, exact hits, unsorted offsets
    task automatic test_directed_corners();
        // No offsets at all: one device gets [0, 0)
        send_entry(KIND_DEVICE, 32'h0000_0000, 1'b1);
        // One offset, last flag on it ignored, extreme ids
        send_entry(KIND_OFFSET, 32'hFFFF_FFFF, 1'b1);
        send_entry(KIND_DEVICE, 32'h0000_FFFF, 1'b0);
        send_entry(KIND_DEVICE, 32'hFFFF_1234, 1'b1);
        // Empty rows: exact tie between two cut candidates
        repeat (4) send_entry(KIND_OFFSET, 32'd0, 1'b0);
        send_entry(KIND_DEVICE, 32'd1, 1'b0);
        send_entry(KIND_DEVICE, 32'd2, 1'b1);
        // Cut lands exactly on the target
        send_entry(KIND_OFFSET, 32'd5, 1'b0);
        send_entry(KIND_OFFSET, 32'd6, 1'b0);
        send_entry(KIND_OFFSET, 32'd7, 1'b0);
        send_entry(KIND_DEVICE, 32'h0000_8000, 1'b0);
        send_entry(KIND_DEVICE, 32'h0000_7FFF, 1'b1);
        // Offsets out of order, full 32-bit swing
        send_entry(KIND_OFFSET, 32'hFFFF_FFFF, 1'b0);
        send_entry(KIND_OFFSET, 32'h0000_0000, 1'b0);
        send_entry(KIND_OFFSET, 32'h8000_0000, 1'b1);
        send_entry(KIND_OFFSET, 32'h0000_0007, 1'b0);
        send_entry(KIND_DEVICE, 32'hAAAA_5555, 1'b0);
        send_entry(KIND_DEVICE, 32'h5555_AAAA, 1'b0);
        send_entry(KIND_DEVICE, 32'h0F0F_F0F0, 1'b1);
    endtask

    // More devices than the store holds; the final device itself is dropped
    task automatic test_device_overflow();
        send_csr_offsets(8, 32'd123, 15);
        send_device_list(MAX_DEVICES + 3);
        // Flag must be clear on the next matrix
        send_csr_offsets(6, 32'd0, 4);
        send_device_list(2);
    endtask

    // Hold the output for a long stretch while the sender keeps offering
    task automatic test_output_holdoff();
        drain_ranges();
        hold_requests++;
        send_csr_offsets(12, 32'd0, 9);
        send_device_list(6);
        send_csr_offsets(8, 32'd1000, 5);
        send_device_list(3);
    endtask

    // Random matrices: mostly well formed, some noise and broken lists
    task automatic test_random_matrices();
        int                 first_sent, first_pred, shape, rows, max_len, n;
        logic [VALUE_W-1:0] base;
        first_sent = n_sent;
        first_pred = n_predicted;
        while (n_sent - first_sent < RANDOM_ITEMS || n_predicted - first_pred < RANDOM_RANGES)
        begin
            shape = $urandom_range(0, 9);
            if (shape <= 6) begin
                rows    = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 40)
                                                       : $urandom_range(1, 24);
                base    = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(0, 32'h7FFF_FFFF);
                case ($urandom_range(0, 3))
                    0:       max_len = 0;
                    1:       max_len = 3;
                    2:       max_len = 20;
                    default: max_len = 5000;
                endcase
                send_csr_offsets(rows, base, max_len);
                send_device_list(($urandom_range(0, 9) == 0) ? $urandom_range(17, 19)
                                                             : $urandom_range(1, 16));
            end else if (shape <= 8) begin
                n = $urandom_range(2, 10);
                repeat (n) send_entry(KIND_OFFSET, $urandom(), 1'($urandom_range(0, 1)));
                send_device_list($urandom_range(1, 6));
            end else begin
                n = $urandom_range(0, 1);
                repeat (n) send_entry(KIND_OFFSET, $urandom(), 1'($urandom_range(0, 1)));
                send_device_list($urandom_range(1, 4));
            end
        end
    endtask

    // Compare each output transaction with the oldest expected range
    always @(posedge i_clk) begin
        t_row_range got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_device_id, o_first_row, o_end_row, o_last_range, o_overflow};
            if (range_q.size() == 0) begin
                report_mismatch($sformatf("unexpected range dev %h [%0d, %0d)",
                                          got.device_id, got.first_row, got.end_row));
            end else begin
                want = range_q.pop_front();
                if (got.device_id != want.device_id)
                    report_mismatch($sformatf("device_id got %h want %h",
                                              got.device_id, want.device_id));
                if (got.first_row != want.first_row)
                    report_mismatch($sformatf("first_row got %0d want %0d (dev %h)",
                                              got.first_row, want.first_row, want.device_id));
                if (got.end_row != want.end_row)
                    report_mismatch($sformatf("end_row got %0d want %0d (dev %h)",
                                              got.end_row, want.end_row, want.device_id));
                if (got.last_range != want.last_range)
                    report_mismatch($sformatf("last_range got %b want %b (dev %h)",
                                              got.last_range, want.last_range, want.device_id));
                if (got.overflow != want.overflow)
                    report_mismatch($sformatf("overflow got %b want %b (dev %h)",
                                              got.overflow, want.overflow, want.device_id));
            end
            n_checked++;
        end
    end

    // Drive the output stall: rotating patterns plus requested long holds
    initial begin : rx_stall_driver
        t_rx_mode mode;
        int       mode_left, hold_left, phase, hold_seen;
        mode      = RX_FREE;
        mode_left = 50;
        hold_left = 0;
        phase     = 0;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 150);
            end else begin
                mode_left--;
            end
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                case (mode)
                    RX_FREE:     i_stall <= 1'b0;
                    RX_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY:    i_stall <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: i_stall <= (phase % 5 < 2);
                    default:     i_stall <= 1'b0;
                endcase
            end
        end
    end

    // Abort when no transaction moves on either side for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle = 0;
            else idle++;
        end
        $display("[%0t] Timeout: no transaction for %0d cycles, %0d ranges outstanding",
                 $realtime, WATCHDOG_LIMIT, range_q.size());
        $display("Verification failed");
        $finish;
    end

    initial begin : main_sequence
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_device_overflow();
        test_output_holdoff();
        test_random_matrices();

        // Let the last ranges out, then watch for stray output
        drain_ranges();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Summary: %0d input transactions, %0d partitions, %0d ranges checked",
                 n_sent, n_partitions, n_checked);
        $display("Covered empty, tied, unsorted and overflowing matrices and a long output hold");
        if (mismatches == 0 && range_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d ranges missing", mismatches, range_q.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/nbrp_pkg.sv
src/nbrp_offset_ram.sv
src/nbrp_weight_unit.sv
src/nonzero_balanced_row_partition_core.sv
test/testbench.sv
